/* rtl/sho_pkg.sv */
package sho_pkg;

   // Number of spin sites held in a basis index; a site at or above it never matches.
   localparam int SITE_COUNT = 32;

   localparam int INDEX_W = 32;
   localparam int AMP_W   = 32;
   localparam int COUP_W  = 32;
   localparam int SITE_W  = 5;
   localparam int MODE_W  = 3;
   localparam int PROD_W  = AMP_W + COUP_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W   = 32;
   localparam int DATA_W  = INDEX_W + 2 * AMP_W;

   // Term modes.
   localparam logic [MODE_W-1:0] MODE_EXCHANGE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PAIRLIFT  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DIAGONAL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HOP_B     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HOP_A     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_HOP_BOTH  = 3'd5;

   // Register indexes on the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SITE_A      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SITE_B      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_A      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_B      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_RE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_IM = 3'd6;

   // Rounding and saturation bounds for a Q10.54 sum going to Q1.30.
   localparam logic signed [SUM_W-1:0] SUM_HI =
      (SUM_W'(1) <<< 55) - (SUM_W'(1) <<< 23);
   localparam logic signed [SUM_W-1:0] SUM_LO =
      -(SUM_W'(1) <<< 55) - (SUM_W'(1) <<< 23);
   localparam logic signed [SUM_W-1:0] SUM_RND = SUM_W'(1) <<< 23;
   localparam int FRAC_SHIFT = 24;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SITE_W-1:0] site_a;
      logic [SITE_W-1:0] site_b;
      logic              spin_a;
      logic              spin_b;
   } term_cfg_type;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] target;
   } match_type;

endpackage

/* rtl/sho_match.sv */
module sho_match
   import sho_pkg::*;
(
   input  term_cfg_type       cfg,
   input  logic [INDEX_W-1:0] basis_index,
   output match_type          result
);

   logic [INDEX_W-1:0] mask_a;
   logic [INDEX_W-1:0] mask_b;
   logic [INDEX_W-1:0] flip_b;
   logic               bit_a;
   logic               bit_b;
   logic               bit_a_after;
   logic               site_ok;

   always_comb begin
      mask_a      = INDEX_W'(1) << cfg.site_a;
      mask_b      = INDEX_W'(1) << cfg.site_b;
      flip_b      = basis_index ^ mask_b;
      bit_a       = basis_index[cfg.site_a];
      bit_b       = basis_index[cfg.site_b];
      // Modes that hop at site B first test site A on the flipped index.
      bit_a_after = flip_b[cfg.site_a];
      site_ok     = (int'(cfg.site_a) < SITE_COUNT) && (int'(cfg.site_b) < SITE_COUNT);

      result.hit    = 1'b0;
      result.target = basis_index;
      unique case (cfg.mode)
         MODE_EXCHANGE: begin
            result.hit    = bit_a != bit_b;
            result.target = basis_index ^ mask_a ^ mask_b;
         end
         MODE_PAIRLIFT: begin
            result.hit    = bit_a == bit_b;
            result.target = basis_index ^ mask_a ^ mask_b;
         end
         MODE_DIAGONAL: begin
            result.hit    = (bit_a == cfg.spin_a) && (bit_b == cfg.spin_b);
            result.target = basis_index;
         end
         MODE_HOP_B: begin
            result.hit    = (bit_b == cfg.spin_b) && (bit_a_after == cfg.spin_a);
            result.target = flip_b;
         end
         MODE_HOP_A: begin
            result.hit    = (bit_b == cfg.spin_b) && (bit_a == cfg.spin_a);
            result.target = basis_index ^ mask_a;
         end
         MODE_HOP_BOTH: begin
            result.hit    = (bit_b == cfg.spin_b) && (bit_a_after == cfg.spin_a);
            result.target = flip_b ^ mask_a;
         end
         default: begin
            result.hit    = 1'b0;
            result.target = basis_index;
         end
      endcase
      result.hit = result.hit && site_ok;
   end

endmodule

/* rtl/spin_half_operator_apply.sv */
// Applies one spin-1/2 Hamiltonian term to a stream of basis states. Each input transfer
// carries a basis index and a complex Q1.30 amplitude; when the spins at the two configured
// sites fit the configured mode, one result leaves with the target index and the amplitude
// times the complex Q7.24 coupling, rounded to nearest (ties up) and saturated to Q1.30.
// Non-matching states produce no result. The block takes one item per cycle while the output is
// not stalled and passes it through four register stages: site match, four 32x32 multipliers,
// the complex sums, then rounding and saturation into the output register, where the result
// waits until it is taken. The user must write configuration only while no item is in flight;
// the block itself does not enforce this.
module spin_half_operator_apply
   import sho_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // basis_index, amp_re, amp_im
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata    // target_index, update_re, update_im
);

   term_cfg_type              cfg_ff;
   logic signed [COUP_W-1:0]  coup_re_ff;
   logic signed [COUP_W-1:0]  coup_im_ff;

   match_type                 match;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic                      ld1, ld2, ld3, ld4;

   logic [INDEX_W-1:0]        tgt1_ff, tgt2_ff, tgt3_ff, tgt4_ff;
   logic signed [AMP_W-1:0]   ar1_ff, ai1_ff;
   logic signed [PROD_W-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [SUM_W-1:0]   s_re_ff, s_im_ff;
   logic signed [SUM_W-1:0]   s_re_in, s_im_in;
   logic [AMP_W-1:0]          up_re_ff, up_im_ff;
   logic [AMP_W-1:0]          up_re_in, up_im_in;

   function automatic logic [AMP_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] r;
      r = (s + SUM_RND) >>> FRAC_SHIFT;
      priority if (s >= SUM_HI) begin
         return {1'b0, {(AMP_W-1){1'b1}}};
      end else if (s < SUM_LO) begin
         return {1'b1, {(AMP_W-1){1'b0}}};
      end else begin
         return r[AMP_W-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_EXCHANGE;
         cfg_ff.site_a <= SITE_W'(0);
         cfg_ff.site_b <= SITE_W'(1);
         cfg_ff.spin_a <= 1'b0;
         cfg_ff.spin_b <= 1'b0;
         coup_re_ff    <= '0;
         coup_im_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:        cfg_ff.mode   <= csr_wdata[MODE_W-1:0];
            CSR_SITE_A:      cfg_ff.site_a <= csr_wdata[SITE_W-1:0];
            CSR_SITE_B:      cfg_ff.site_b <= csr_wdata[SITE_W-1:0];
            CSR_SPIN_A:      cfg_ff.spin_a <= csr_wdata[0];
            CSR_SPIN_B:      cfg_ff.spin_b <= csr_wdata[0];
            CSR_COUPLING_RE: coup_re_ff    <= csr_wdata[COUP_W-1:0];
            CSR_COUPLING_IM: coup_im_ff    <= csr_wdata[COUP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sho_match u_match (
      .cfg         (cfg_ff),
      .basis_index (req_tdata[INDEX_W-1:0]),
      .result      (match)
   );

   // A stage loads when it is empty or its content moves on in the same cycle.
   assign ld4        = !v4_ff || rsp_tready;
   assign ld3        = !v3_ff || ld4;
   assign ld2        = !v2_ff || ld3;
   assign ld1        = !v1_ff || ld2;
   assign req_tready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         // Items without a match are dropped at the first stage.
         if (ld1) v1_ff <= req_tvalid && match.hit;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
      end
   end

   always_comb begin
      s_re_in  = SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
      s_im_in  = SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
      up_re_in = round_sat(s_re_ff);
      up_im_in = round_sat(s_im_ff);
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         tgt1_ff <= match.target;
         ar1_ff  <= req_tdata[INDEX_W +: AMP_W];
         ai1_ff  <= req_tdata[INDEX_W + AMP_W +: AMP_W];
      end
      if (ld2) begin
         tgt2_ff <= tgt1_ff;
         p_rr_ff <= coup_re_ff * ar1_ff;
         p_ii_ff <= coup_im_ff * ai1_ff;
         p_ri_ff <= coup_re_ff * ai1_ff;
         p_ir_ff <= coup_im_ff * ar1_ff;
      end
      if (ld3) begin
         tgt3_ff <= tgt2_ff;
         s_re_ff <= s_re_in;
         s_im_ff <= s_im_in;
      end
      if (ld4) begin
         tgt4_ff  <= tgt3_ff;
         up_re_ff <= up_re_in;
         up_im_ff <= up_im_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {up_im_ff, up_re_ff, tgt4_ff};

endmodule

/* sim/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sho_pkg::*;

   localparam int LATENCY      = 4;
   localparam int DRAIN_CYCLES = LATENCY + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 50;

   // Mode codes the block does not define; they must never produce a result.
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   localparam logic [AMP_W-1:0]  Q130_MAX     = 32'h7FFF_FFFF;
   localparam logic [AMP_W-1:0]  Q130_MIN     = 32'h8000_0000;
   localparam logic [COUP_W-1:0] COUPLING_ONE = 32'h0100_0000;
   localparam logic [COUP_W-1:0] COUPLING_LSB = 32'h0000_0001;

   localparam logic signed [65:0] SAT_HI = (66'sd1 <<< 55) - (66'sd1 <<< 23);
   localparam logic signed [65:0] SAT_LO = -(66'sd1 <<< 55) - (66'sd1 <<< 23);
   localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< 23;

   // Declared high field first so that target_index lands in the low bits.
   typedef struct packed {
      logic [AMP_W-1:0]   upd_im;
      logic [AMP_W-1:0]   upd_re;
      logic [INDEX_W-1:0] target;
   } update_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_MODE;
   logic [CSR_W-1:0]     csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;

   term_cfg_type      cfg;
   logic signed [31:0] cfg_cre;
   logic signed [31:0] cfg_cim;

   update_type pending_updates[$];
   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 15;
   int recv_idle_pct  = 55;

   spin_half_operator_apply u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // basis_index, amp_re, amp_im
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // target_index, update_re, update_im
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_updates.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Q10.54 sum to Q1.30: round half toward plus infinity, then saturate.
   function automatic logic [AMP_W-1:0] round_to_q130(input logic signed [65:0] s);
      logic signed [65:0] r;
      if (s >= SAT_HI) return Q130_MAX;
      if (s < SAT_LO) return Q130_MIN;
      r = (s + HALF_LSB) >>> 24;
      return r[AMP_W-1:0];
   endfunction

   function automatic logic apply_term(input logic [INDEX_W-1:0] idx,
                                       input logic signed [31:0] ar,
                                       input logic signed [31:0] ai,
                                       output update_type upd);
      logic [INDEX_W-1:0] ma;
      logic [INDEX_W-1:0] mb;
      logic [INDEX_W-1:0] flipped;
      logic               a;
      logic               b;
      logic               hit;
      logic signed [65:0] sum_re;
      logic signed [65:0] sum_im;
      ma         = 32'd1 << cfg.site_a;
      mb         = 32'd1 << cfg.site_b;
      a          = idx[cfg.site_a];
      b          = idx[cfg.site_b];
      flipped    = idx ^ mb;
      hit        = 1'b0;
      upd.target = idx;
      if (cfg.site_a < SITE_COUNT && cfg.site_b < SITE_COUNT) begin
         case (cfg.mode)
            MODE_EXCHANGE: begin
               hit        = (a != b);
               upd.target = idx ^ ma ^ mb;
            end
            MODE_PAIRLIFT: begin
               hit        = (a == b);
               upd.target = idx ^ ma ^ mb;
            end
            MODE_DIAGONAL: begin
               hit = (a == cfg.spin_a) && (b == cfg.spin_b);
            end
            // The site A test looks at the index after site B has been flipped.
            MODE_HOP_B: begin
               hit        = (b == cfg.spin_b) && (flipped[cfg.site_a] == cfg.spin_a);
               upd.target = flipped;
            end
            MODE_HOP_A: begin
               hit        = (b == cfg.spin_b) && (a == cfg.spin_a);
               upd.target = idx ^ ma;
            end
            MODE_HOP_BOTH: begin
               hit        = (b == cfg.spin_b) && (flipped[cfg.site_a] == cfg.spin_a);
               upd.target = flipped ^ ma;
            end
            default: hit = 1'b0;
         endcase
      end
      sum_re     = cfg_cre * ar - cfg_cim * ai;
      sum_im     = cfg_cre * ai + cfg_cim * ar;
      upd.upd_re = round_to_q130(sum_re);
      upd.upd_im = round_to_q130(sum_im);
      return hit;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch on %s at cycle %0d: got %h, expected %h", field, cycle_count,
                  got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_updates
      update_type got;
      update_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_updates.size() == 0) begin
            report_mismatch("result with none expected, target", got.target, '0);
         end else begin
            want = pending_updates.pop_front();
            if (got.target !== want.target) report_mismatch("target_index", got.target,
                                                            want.target);
            if (got.upd_re !== want.upd_re) report_mismatch("update_re", got.upd_re,
                                                            want.upd_re);
            if (got.upd_im !== want.upd_im) report_mismatch("update_im", got.upd_im,
                                                            want.upd_im);
         end
      end
   end

   task automatic send_state(input logic [INDEX_W-1:0] idx, input logic [AMP_W-1:0] ar,
                             input logic [AMP_W-1:0] ai);
      update_type upd;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {ai, ar, idx};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (apply_term(idx, ar, ai, upd)) pending_updates.push_back(upd);
   endtask

   // Holds the input off until every expected result is out and the pipeline is
   // empty; items that produce no result are dropped at the first stage.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      case (index)
         CSR_MODE:        cfg.mode   = value[MODE_W-1:0];
         CSR_SITE_A:      cfg.site_a = value[SITE_W-1:0];
         CSR_SITE_B:      cfg.site_b = value[SITE_W-1:0];
         CSR_SPIN_A:      cfg.spin_a = value[0];
         CSR_SPIN_B:      cfg.spin_b = value[0];
         CSR_COUPLING_RE: cfg_cre    = value;
         CSR_COUPLING_IM: cfg_cim    = value;
         default: ;
      endcase
   endtask

   task automatic set_term(input logic [MODE_W-1:0] mode, input logic [SITE_W-1:0] sa,
                           input logic [SITE_W-1:0] sb, input logic spa, input logic spb,
                           input logic [COUP_W-1:0] cre, input logic [COUP_W-1:0] cim);
      drain_results();
      write_reg(CSR_MODE, CSR_W'(mode));
      write_reg(CSR_SITE_A, CSR_W'(sa));
      write_reg(CSR_SITE_B, CSR_W'(sb));
      write_reg(CSR_SPIN_A, CSR_W'(spa));
      write_reg(CSR_SPIN_B, CSR_W'(spb));
      write_reg(CSR_COUPLING_RE, cre);
      write_reg(CSR_COUPLING_IM, cim);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [INDEX_W-1:0] pick_index();
      case ($urandom_range(19))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [AMP_W-1:0] pick_amp();
      case ($urandom_range(11))
         0:       return Q130_MIN;
         1:       return Q130_MAX;
         2:       return '0;
         3:       return ($urandom & 32'hFF00_0000) | 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly modest couplings so that many products land inside the Q1.30 range.
   function automatic logic [COUP_W-1:0] pick_coupling();
      logic [COUP_W-1:0] p;
      case ($urandom_range(9))
         0: return Q130_MAX;
         1: return Q130_MIN;
         2: return '0;
         3: begin
            p = 32'd1 << $urandom_range(26);
            return $urandom_range(1) ? p : -p;
         end
         4:       return $urandom;
         default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
      endcase
   endfunction

   function automatic logic [SITE_W-1:0] pick_site();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         default: return SITE_W'($urandom);
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] place_spins(input logic [INDEX_W-1:0] base,
                                                      input logic a, input logic b);
      logic [INDEX_W-1:0] r;
      r              = base;
      r[cfg.site_a]  = a;
      r[cfg.site_b]  = b;
      return r;
   endfunction

   task automatic random_term();
      logic [MODE_W-1:0] mode;
      logic [SITE_W-1:0] sa;
      logic [SITE_W-1:0] sb;
      if ($urandom_range(99) < 6) mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
      else mode = MODE_W'($urandom_range(MODE_HOP_BOTH));
      sa = pick_site();
      sb = ($urandom_range(99) < 15) ? sa : pick_site();
      set_term(mode, sa, sb, 1'($urandom), 1'($urandom), pick_coupling(), pick_coupling());
   endtask

   task automatic test_extremes();
      set_term(MODE_PAIRLIFT, '1, '1, 1'b0, 1'b0, Q130_MAX, Q130_MIN);
      send_state('0, Q130_MIN, Q130_MIN);
      send_state('1, Q130_MAX, Q130_MAX);
      // Both products at +2^62: the imaginary sum overflows 64 bits and must saturate.
      set_term(MODE_PAIRLIFT, '1, '1, 1'b1, 1'b1, Q130_MIN, Q130_MIN);
      send_state(32'h5A5A_5A5A, Q130_MIN, Q130_MIN);
      send_state(32'hA5A5_A5A5, Q130_MAX, Q130_MIN);
   endtask

   task automatic test_rounding();
      set_term(MODE_PAIRLIFT, '0, '0, 1'b0, 1'b0, COUPLING_LSB, '0);
      send_state(pick_index(), 32'h0080_0000, 32'hFF80_0000);
      send_state(pick_index(), 32'h007F_FFFF, 32'h0080_0001);
      set_term(MODE_PAIRLIFT, '0, '0, 1'b0, 1'b0, '0, COUPLING_LSB);
      send_state(pick_index(), 32'hFF80_0000, 32'h0080_0000);
   endtask

   task automatic test_modes();
      logic [MODE_W-1:0] mode;
      mode = MODE_EXCHANGE;
      repeat (MODE_HOP_BOTH + 1) begin
         set_term(mode, 5'd3, 5'd7, 1'b1, 1'b0, COUPLING_ONE, 32'h0080_0000);
         if (mode == MODE_PAIRLIFT) begin
            send_state(place_spins(pick_index(), 1'b0, 1'b0), pick_amp(), pick_amp());
            send_state(place_spins(pick_index(), 1'b0, 1'b1), pick_amp(), pick_amp());
         end else begin
            send_state(place_spins(pick_index(), 1'b1, 1'b0), pick_amp(), pick_amp());
            send_state(place_spins(pick_index(), 1'b1, 1'b1), pick_amp(), pick_amp());
         end
         mode++;
      end
   endtask

   task automatic test_equal_sites();
      set_term(MODE_EXCHANGE, 5'd5, 5'd5, 1'b0, 1'b0, COUPLING_ONE, '0);
      send_state(pick_index(), pick_amp(), pick_amp());
      set_term(MODE_HOP_B, 5'd5, 5'd5, 1'b1, 1'b0, COUPLING_ONE, COUPLING_ONE);
      send_state(place_spins(pick_index(), 1'b0, 1'b0), pick_amp(), pick_amp());
      set_term(MODE_HOP_BOTH, 5'd5, 5'd5, 1'b1, 1'b0, COUPLING_ONE, COUPLING_ONE);
      send_state(place_spins(pick_index(), 1'b0, 1'b0), pick_amp(), pick_amp());
   endtask

   task automatic test_unused_modes();
      set_term(MODE_SPARE_6, 5'd2, 5'd9, 1'b0, 1'b0, COUPLING_ONE, COUPLING_ONE);
      send_state(pick_index(), pick_amp(), pick_amp());
      set_term(MODE_SPARE_7, 5'd2, 5'd9, 1'b1, 1'b1, COUPLING_ONE, COUPLING_ONE);
      send_state(pick_index(), pick_amp(), pick_amp());
   endtask

   task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct);
      int sent;
      int batch;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent          = 0;
      while (sent < n_items) begin
         random_term();
         batch = $urandom_range(60, 20);
         repeat (batch) begin
            if ($urandom_range(49) == 0) drain_results();
            send_state(pick_index(), pick_amp(), pick_amp());
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(550, 15, 55);
      run_random_phase(550, 55, 15);
      run_random_phase(550, 0, 0);
   endtask

   initial begin
      cfg.mode   = MODE_EXCHANGE;
      cfg.site_a = 5'd0;
      cfg.site_b = 5'd1;
      cfg.spin_a = 1'b0;
      cfg.spin_b = 1'b0;
      cfg_cre    = '0;
      cfg_cim    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_rounding();
      test_modes();
      test_equal_sites();
      test_unused_modes();
      test_random_traffic();

      drain_results();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
